// ===== rtl/array_list_with_cursor_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the array list block
// Shared concurrent assertion forms, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef ARRAY_LIST_WITH_CURSOR_MACROS_SVH
`define ARRAY_LIST_WITH_CURSOR_MACROS_SVH

// Same-cycle implication
`define ALCUR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define ALCUR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/alcur_pkg.sv =====
// ----------------------------------------------------------------------------
// alcur_pkg
// Types and constants of the array list with iteration cursor.
// ----------------------------------------------------------------------------
package alcur_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 7;

  // Operation selector
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_FIRST  = 2'd1,
    KIND_NEXT   = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_e;

  // Result status
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_END   = 3'd3,
    ST_NOCUR = 3'd4
  } status_e;

  // One result beat
  typedef struct packed {
    logic                     ok;
    status_e                  status;
    logic signed [DATA_W-1:0] value;
    logic [COUNT_W-1:0]       count;
  } res_t;

endpackage

// ===== rtl/array_list_with_cursor.sv =====
// ----------------------------------------------------------------------------
// array_list_with_cursor
// Ordered list of signed 32-bit values with an iteration cursor.
// ----------------------------------------------------------------------------
// One result beat per operation beat. Insert and any failed operation go
// from decode straight to the response; first and next pass through a RAM
// read state, and remove also shifts the elements behind the removed one
// down one RAM slot per cycle through the single read port of the element
// RAM. A finished result waits in an output register so the next operation
// can be taken while it is unclaimed. The element RAM needs no clearing after
// reset; only slots below the count are ever read.
module array_list_with_cursor #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // operation beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value_in
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [0] ok, [3:1] status, [35:4] value_out,
                                      // [42:36] count, [47:43] zero
);

  localparam int unsigned AW = $clog2(CAPACITY);

  logic                           res_valid;
  logic                           res_ready;
  alcur_pkg::res_t                res;
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [alcur_pkg::DATA_W-1:0]   ram_wdata;
  logic                           ram_re;
  logic [AW-1:0]                  ram_raddr;
  logic [alcur_pkg::DATA_W-1:0]   ram_rdata;
  logic                           out_vld_q;
  alcur_pkg::res_t                out_q;

  alcur_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_kind_i   (alcur_pkg::kind_e'(s_axis_tuser)),
    .in_value_i  (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  alcur_ram #(
    .WIDTH (alcur_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register
  assign res_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  // Pack the result beat, ok in the lowest bit
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0, out_q.count, out_q.value, out_q.status, out_q.ok};

endmodule

// ===== rtl/alcur_ram.sv =====
// ----------------------------------------------------------------------------
// alcur_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module alcur_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/alcur_ctrl.sv =====
// ----------------------------------------------------------------------------
// alcur_ctrl
// Sequencer: decodes an operation, drives the element RAM and runs the
// element shift of a remove, one element per cycle.
// ----------------------------------------------------------------------------
module alcur_ctrl #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // operation in
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  alcur_pkg::kind_e                      in_kind_i,
  input  logic signed [alcur_pkg::DATA_W-1:0]   in_value_i,
  // result out
  output logic                                  res_valid_o,
  input  logic                                  res_ready_i,
  output alcur_pkg::res_t                       res_o,
  // element RAM
  output logic                                  ram_we_o,
  output logic [$clog2(CAPACITY)-1:0]           ram_waddr_o,
  output logic [alcur_pkg::DATA_W-1:0]          ram_wdata_o,
  output logic                                  ram_re_o,
  output logic [$clog2(CAPACITY)-1:0]           ram_raddr_o,
  input  logic [alcur_pkg::DATA_W-1:0]          ram_rdata_i
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0]                          state_q, state_d;
  logic [CW-1:0]                       cnt_q, cnt_d;
  logic                                cur_vld_q, cur_vld_d;
  logic [AW-1:0]                       cur_q, cur_d;
  logic                                is_rm_q, is_rm_d;
  logic [AW-1:0]                       pos_q, pos_d;
  logic [AW-1:0]                       rd_addr_q, rd_addr_d;
  alcur_pkg::status_e                  status_q, status_d;
  logic [alcur_pkg::DATA_W-1:0]        value_q, value_d;

  logic [CW-1:0]                       rd_next;
  logic                                more;

  // Next shift source and whether one is left
  assign rd_next = CW'(rd_addr_q) + CW'(1);
  assign more    = (rd_next < cnt_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cur_vld_d   = cur_vld_q;
    cur_d       = cur_q;
    is_rm_d     = is_rm_q;
    pos_d       = pos_q;
    rd_addr_d   = rd_addr_q;
    status_d    = status_q;
    value_d     = value_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = AW'(cnt_q);
    ram_wdata_o = in_value_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = rd_addr_q;

    case (state_q)
      // Decode; failures go straight to the response
      S_IDLE: begin
        if (in_valid_i) begin
          status_d = alcur_pkg::ST_OK;
          value_d  = '0;
          state_d  = S_RESP;
          case (in_kind_i)
            alcur_pkg::KIND_INSERT: begin
              if (cnt_q == CW'(CAPACITY)) begin
                status_d = alcur_pkg::ST_FULL;
              end else begin
                ram_we_o = 1'b1;
                cnt_d    = cnt_q + CW'(1);
              end
            end
            alcur_pkg::KIND_FIRST: begin
              if (cnt_q == '0) begin
                status_d = alcur_pkg::ST_EMPTY;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = '0;
                rd_addr_d   = '0;
                cur_vld_d   = 1'b1;
                cur_d       = '0;
                is_rm_d     = 1'b0;
                state_d     = S_READ;
              end
            end
            alcur_pkg::KIND_NEXT: begin
              if (cnt_q == '0) begin
                status_d = alcur_pkg::ST_EMPTY;
              end else if (cur_vld_q && (CW'(cur_q) >= cnt_q - CW'(1))) begin
                status_d = alcur_pkg::ST_END;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = cur_vld_q ? cur_q + AW'(1) : '0;
                rd_addr_d   = ram_raddr_o;
                cur_vld_d   = 1'b1;
                cur_d       = ram_raddr_o;
                is_rm_d     = 1'b0;
                state_d     = S_READ;
              end
            end
            alcur_pkg::KIND_REMOVE: begin
              if (cnt_q == '0) begin
                status_d = alcur_pkg::ST_EMPTY;
              end else if (!cur_vld_q || (CW'(cur_q) >= cnt_q)) begin
                status_d = alcur_pkg::ST_NOCUR;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = cur_q;
                rd_addr_d   = cur_q;
                pos_d       = cur_q;
                is_rm_d     = 1'b1;
                state_d     = S_READ;
              end
            end
            default: begin
              status_d = alcur_pkg::ST_OK;
            end
          endcase
        end
      end

      // Read data is back; remove starts its shift here
      S_READ: begin
        value_d = ram_rdata_i;
        if (!is_rm_q) begin
          state_d = S_RESP;
        end else if (more) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = AW'(rd_next);
          rd_addr_d   = AW'(rd_next);
          state_d     = S_SHIFT;
        end else begin
          cnt_d     = cnt_q - CW'(1);
          cur_vld_d = (pos_q != '0);
          cur_d     = pos_q - AW'(1);
          state_d   = S_RESP;
        end
      end

      // Move one element down: write slot below what was just read.
      // Read and write addresses always differ, so no forwarding is needed.
      S_SHIFT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = rd_addr_q - AW'(1);
        ram_wdata_o = ram_rdata_i;
        if (more) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = AW'(rd_next);
          rd_addr_d   = AW'(rd_next);
        end else begin
          cnt_d     = cnt_q - CW'(1);
          cur_vld_d = (pos_q != '0);
          cur_d     = pos_q - AW'(1);
          state_d   = S_RESP;
        end
      end

      // Hand the result to the output register
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      cur_vld_q <= 1'b0;
      cur_q     <= '0;
      is_rm_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cur_vld_q <= cur_vld_d;
      cur_q     <= cur_d;
      is_rm_q   <= is_rm_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    rd_addr_q <= rd_addr_d;
    status_q  <= status_d;
    value_q   <= value_d;
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign res_valid_o  = (state_q == S_RESP);
  assign res_o.ok     = (status_q == alcur_pkg::ST_OK);
  assign res_o.status = status_q;
  assign res_o.value  = value_q;
  assign res_o.count  = alcur_pkg::COUNT_W'(cnt_q);

endmodule

// ===== rtl/alcur_chk.sv =====
// ----------------------------------------------------------------------------
// alcur_chk
// Port-level checks of the array list block, bound to the top level.
// ----------------------------------------------------------------------------
`include "array_list_with_cursor_macros.svh"

module alcur_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  logic in_beat;

  assign in_beat = s_axis_tvalid && s_axis_tready;

  // A stalled result stays presented
  `ALCUR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // The ok flag matches the status code
  `ALCUR_ASSERT_IMP(a_ok_status, clk_i, rst_ni, m_axis_tvalid,
    m_axis_tdata[0] == (m_axis_tdata[3:1] == alcur_pkg::ST_OK))

  // Failed operations return a zero value
  `ALCUR_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[0],
    m_axis_tdata[35:4] == 32'd0)

  // An accepted operation is not followed by another in the next cycle
  `ALCUR_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, in_beat, !s_axis_tready)

endmodule

bind array_list_with_cursor alcur_chk u_alcur_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/array_list_with_cursor_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// array_list_with_cursor_tb
// Drives operation beats into the cursor list and checks every result beat
// against the expectation of its directed row or else against a local model
// of the list. A directed table covers the empty, full, end-of-list and
// no-cursor cases and the extreme values. Random traffic follows, grouped
// into fill, walk, drain and mixed phases. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module array_list_with_cursor_tb;

  localparam int CAPACITY       = 64;
  localparam int RAND_ITEMS     = 1766;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = CAPACITY + 8;
  localparam int DIR_ROWS       = 24;

  // Random phases
  localparam int PH_FILL  = 0;
  localparam int PH_WALK  = 1;
  localparam int PH_DRAIN = 2;
  localparam int PH_MIXED = 3;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] value_in
  logic [1:0]  s_axis_tuser;   // [1:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [0] ok, [3:1] status, [35:4] value_out,
                               // [42:36] count, [47:43] zero

  array_list_with_cursor #(.CAPACITY(CAPACITY)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Directed stimulus row; exp is used only when has_exp is set
  typedef struct {
    alcur_pkg::kind_e     op;
    logic signed [31:0]   din;
    int                   reps;
    bit                   has_exp;
    alcur_pkg::res_t      exp;
  } dir_row_t;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // empty list after reset
    '{alcur_pkg::KIND_NEXT,   32'sh0000_0000, 1, 1'b1,
      '{1'b0, alcur_pkg::ST_EMPTY, 32'sh0, 7'd0}},
    '{alcur_pkg::KIND_FIRST,  32'sh0000_0000, 1, 1'b1,
      '{1'b0, alcur_pkg::ST_EMPTY, 32'sh0, 7'd0}},
    '{alcur_pkg::KIND_REMOVE, 32'sh0000_0000, 1, 1'b1,
      '{1'b0, alcur_pkg::ST_EMPTY, 32'sh0, 7'd0}},
    // extremes in, then no-position cases
    '{alcur_pkg::KIND_INSERT, 32'sh7FFF_FFFF, 1, 1'b1,
      '{1'b1, alcur_pkg::ST_OK, 32'sh0, 7'd1}},
    '{alcur_pkg::KIND_INSERT, 32'sh8000_0000, 1, 1'b1,
      '{1'b1, alcur_pkg::ST_OK, 32'sh0, 7'd2}},
    '{alcur_pkg::KIND_REMOVE, 32'sh0000_0000, 1, 1'b1,
      '{1'b0, alcur_pkg::ST_NOCUR, 32'sh0, 7'd2}},
    '{alcur_pkg::KIND_NEXT,   32'sh0000_0000, 1, 1'b1,
      '{1'b1, alcur_pkg::ST_OK, 32'sh7FFF_FFFF, 7'd2}},
    '{alcur_pkg::KIND_NEXT,   32'sh0000_0000, 1, 1'b1,
      '{1'b1, alcur_pkg::ST_OK, 32'sh8000_0000, 7'd2}},
    '{alcur_pkg::KIND_NEXT,   32'sh0000_0000, 1, 1'b1,
      '{1'b0, alcur_pkg::ST_END, 32'sh0, 7'd2}},
    // remove last, then element 0 (cursor drops to no position)
    '{alcur_pkg::KIND_REMOVE, 32'sh0000_0000, 1, 1'b1,
      '{1'b1, alcur_pkg::ST_OK, 32'sh8000_0000, 7'd1}},
    '{alcur_pkg::KIND_REMOVE, 32'sh0000_0000, 1, 1'b1,
      '{1'b1, alcur_pkg::ST_OK, 32'sh7FFF_FFFF, 7'd0}},
    '{alcur_pkg::KIND_REMOVE, 32'sh0000_0000, 1, 1'b1,
      '{1'b0, alcur_pkg::ST_EMPTY, 32'sh0, 7'd0}},
    // fill up to capacity and past it
    '{alcur_pkg::KIND_INSERT, 32'shFFFF_FFFF, 1, 1'b1,
      '{1'b1, alcur_pkg::ST_OK, 32'sh0, 7'd1}},
    '{alcur_pkg::KIND_INSERT, 32'sh0000_0000, 1, 1'b1,
      '{1'b1, alcur_pkg::ST_OK, 32'sh0, 7'd2}},
    '{alcur_pkg::KIND_INSERT, 32'shA5A5_5A5A, CAPACITY - 3, 1'b0, '0},
    '{alcur_pkg::KIND_INSERT, 32'sh0000_0001, 1, 1'b1,
      '{1'b1, alcur_pkg::ST_OK, 32'sh0, 7'd64}},
    '{alcur_pkg::KIND_INSERT, 32'sh1234_5678, 1, 1'b1,
      '{1'b0, alcur_pkg::ST_FULL, 32'sh0, 7'd64}},
    '{alcur_pkg::KIND_FIRST,  32'sh0000_0000, 1, 1'b1,
      '{1'b1, alcur_pkg::ST_OK, 32'shFFFF_FFFF, 7'd64}},
    '{alcur_pkg::KIND_NEXT,   32'sh0000_0000, 1, 1'b1,
      '{1'b1, alcur_pkg::ST_OK, 32'sh0, 7'd64}},
    // remove at position 1 of the full list, then head removal
    '{alcur_pkg::KIND_REMOVE, 32'sh0000_0000, 1, 1'b1,
      '{1'b1, alcur_pkg::ST_OK, 32'sh0, 7'd63}},
    '{alcur_pkg::KIND_REMOVE, 32'sh0000_0000, 1, 1'b1,
      '{1'b1, alcur_pkg::ST_OK, 32'shFFFF_FFFF, 7'd62}},
    '{alcur_pkg::KIND_REMOVE, 32'sh0000_0000, 1, 1'b1,
      '{1'b0, alcur_pkg::ST_NOCUR, 32'sh0, 7'd62}},
    '{alcur_pkg::KIND_FIRST,  32'sh0000_0000, 1, 1'b0, '0},
    '{alcur_pkg::KIND_NEXT,   32'sh0000_0000, 1, 1'b0, '0}
  };

  // Local copy of the list
  logic signed [31:0] list_mem [CAPACITY];
  int                 elem_count;
  int                 list_pos;

  alcur_pkg::res_t pending_results [$];
  int   error_count;
  int   idle_cycles = 0;
  bit   sender_burst;
  bit   receiver_burst;

  // Clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Apply one operation to the local list and return its result beat
  function automatic alcur_pkg::res_t apply_list_op(alcur_pkg::kind_e op,
                                                    logic signed [31:0] din);
    alcur_pkg::res_t r;
    int              i;
    r.ok     = 1'b0;
    r.status = alcur_pkg::ST_OK;
    r.value  = '0;
    case (op)
      alcur_pkg::KIND_INSERT: begin
        if (elem_count >= CAPACITY) begin
          r.status = alcur_pkg::ST_FULL;
        end else begin
          list_mem[elem_count] = din;
          elem_count++;
        end
      end
      alcur_pkg::KIND_FIRST: begin
        if (elem_count == 0) begin
          r.status = alcur_pkg::ST_EMPTY;
        end else begin
          list_pos = 0;
          r.value  = list_mem[0];
        end
      end
      alcur_pkg::KIND_NEXT: begin
        if (elem_count == 0) begin
          r.status = alcur_pkg::ST_EMPTY;
        end else if (list_pos >= elem_count - 1) begin
          r.status = alcur_pkg::ST_END;
        end else begin
          list_pos++;
          r.value = list_mem[list_pos];
        end
      end
      default: begin
        if (elem_count == 0) begin
          r.status = alcur_pkg::ST_EMPTY;
        end else if (list_pos < 0 || list_pos >= elem_count) begin
          r.status = alcur_pkg::ST_NOCUR;
        end else begin
          r.value = list_mem[list_pos];
          for (i = list_pos; i + 1 < elem_count; i++) list_mem[i] = list_mem[i + 1];
          elem_count--;
          list_pos--;
        end
      end
    endcase
    r.ok    = (r.status == alcur_pkg::ST_OK);
    r.count = 7'(elem_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
    error_count++;
  endtask

  // Send one operation beat; called and returning just after a falling edge
  task automatic send_op(alcur_pkg::kind_e op, logic signed [31:0] din, bit has_exp,
                         alcur_pkg::res_t exp);
    int              gap;
    alcur_pkg::res_t model_r;
    if ($urandom_range(0, 39) == 0) sender_burst = ~sender_burst;
    gap = sender_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= din;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    model_r = apply_list_op(op, din);
    pending_results.push_back(has_exp ? exp : model_r);
    @(negedge clk_i);
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  // Stimulus
  initial begin
    int                 row;
    int                 k;
    int                 n;
    int                 phase;
    int                 phase_left;
    int                 r;
    alcur_pkg::kind_e   op;
    logic signed [31:0] din;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    error_count   = 0;
    sender_burst  = 1'b0;
    elem_count    = 0;
    list_pos      = -1;
    phase         = PH_FILL;
    phase_left    = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table
    for (row = 0; row < DIR_ROWS; row++) begin
      for (k = 0; k < dir_rows[row].reps; k++)
        send_op(dir_rows[row].op, dir_rows[row].din, dir_rows[row].has_exp,
                dir_rows[row].exp);
    end
    wait_for_drain();

    // Random traffic in phases
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase      = $urandom_range(PH_FILL, PH_MIXED);
        phase_left = $urandom_range(32, 120);
      end
      phase_left--;
      r = $urandom_range(0, 99);
      case (phase)
        PH_FILL:  op = (r < 75) ? alcur_pkg::KIND_INSERT :
                       (r < 80) ? alcur_pkg::KIND_FIRST :
                       (r < 90) ? alcur_pkg::KIND_NEXT : alcur_pkg::KIND_REMOVE;
        PH_WALK:  op = (r < 10) ? alcur_pkg::KIND_FIRST :
                       (r < 80) ? alcur_pkg::KIND_NEXT :
                       (r < 90) ? alcur_pkg::KIND_REMOVE : alcur_pkg::KIND_INSERT;
        PH_DRAIN: op = (r < 15) ? alcur_pkg::KIND_FIRST :
                       (r < 40) ? alcur_pkg::KIND_NEXT :
                       (r < 95) ? alcur_pkg::KIND_REMOVE : alcur_pkg::KIND_INSERT;
        default:  op = alcur_pkg::kind_e'(r % 4);
      endcase
      case ($urandom_range(0, 9))
        0:       din = 32'sh7FFF_FFFF;
        1:       din = 32'sh8000_0000;
        2:       din = 32'sh0000_0000;
        3:       din = 32'shFFFF_FFFF;
        default: din = $urandom;
      endcase
      send_op(op, din, 1'b0, '0);
      if (n == RAND_ITEMS / 2 || $urandom_range(0, 299) == 0) wait_for_drain();
    end

    // Wind down
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("array_list_with_cursor_tb: clean");
    end else begin
      $display("array_list_with_cursor_tb: errors");
    end
    $finish;
  end

  // Result side: random stalls, check each beat against the oldest expectation
  initial begin
    int              stall;
    alcur_pkg::res_t want;
    logic [47:0]     beat;
    m_axis_tready  = 1'b0;
    receiver_burst = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 39) == 0) receiver_burst = ~receiver_burst;
      stall = receiver_burst ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      beat = m_axis_tdata;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", beat[31:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (beat[0] !== want.ok)
          report_mismatch("ok", 32'(beat[0]), 32'(want.ok));
        if (beat[3:1] !== want.status)
          report_mismatch("status", 32'(beat[3:1]), 32'(want.status));
        if (beat[35:4] !== want.value)
          report_mismatch("value", beat[35:4], want.value);
        if (beat[42:36] !== want.count)
          report_mismatch("count", 32'(beat[42:36]), 32'(want.count));
        if (beat[47:43] !== 5'd0)
          report_mismatch("pad", 32'(beat[47:43]), '0);
      end
    end
  end

  // Watchdog: too long without any beat on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("array_list_with_cursor_tb: errors");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/alcur_pkg.sv
rtl/alcur_ram.sv
rtl/alcur_ctrl.sv
rtl/array_list_with_cursor.sv
rtl/alcur_chk.sv
dv/array_list_with_cursor_tb.sv
